### src/pstt_pkg.sv
// pstt_pkg: shared types, constants and op codes of the periodic soft timer table
// used by pstt_update and periodic_soft_timer_table; depends on nothing
package pstt_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int TIMER_AW    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    localparam logic [30:0] WRAP_LIMIT     = 31'h7FFF_FFFF;
    localparam logic [31:0] DEADLINE_SHIFT = 32'h7FFF_FFFF;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_ARM       = 3'd1;
    localparam logic [2:0] OP_POLL      = 3'd2;
    localparam logic [2:0] OP_CLEAR_ONE = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  timer_index;
        logic [31:0] delay_ms;
    } cmd_word_t;

    typedef struct packed {
        logic        expired;
        logic [30:0] now_ms;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] deadline;
    } entry_t;

    // decision of the update unit for one command word
    typedef struct packed {
        logic        expired;
        logic        wr_en;
        entry_t      wr_data;
        logic        act_set;
        logic        act_clr;
        logic        clr_all;
        logic        wrap;
        logic [30:0] time_next;
    } upd_t;

endpackage

### src/pstt_ram.sv
// pstt_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module pstt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### src/pstt_update.sv
// pstt_update: per-word arithmetic of the timer table (tick, arm, poll, clear)
// and the deadline adjustment applied during the wrap sweep; uses pstt_pkg
module pstt_update
    import pstt_pkg::*;
(
    input  logic [2:0]  op,
    input  logic        idx_ok,
    input  logic        active,
    input  logic [30:0] time_now,
    input  logic [31:0] delay_ms,
    input  entry_t      entry,
    output upd_t        upd,
    output entry_t      swept
);

    logic [31:0] time_ext;
    logic [30:0] time_inc;

    assign time_ext = {1'b0, time_now};
    assign time_inc = time_now + 31'd1;

    always_comb
    begin
        upd           = '0;
        upd.time_next = time_now;
        unique case (op)
            OP_TICK:
            begin
                if (time_inc == WRAP_LIMIT)
                begin
                    upd.time_next = '0;
                    upd.wrap      = 1'b1;
                end
                else
                begin
                    upd.time_next = time_inc;
                end
            end
            OP_ARM:
            begin
                upd.wr_en            = idx_ok;
                upd.act_set          = idx_ok;
                upd.wr_data.period   = delay_ms;
                upd.wr_data.deadline = time_ext + delay_ms;
            end
            OP_POLL:
            begin
                // due once the clock has reached the stored deadline
                if (idx_ok && active && (time_ext >= entry.deadline))
                begin
                    upd.expired          = 1'b1;
                    upd.wr_en            = 1'b1;
                    upd.act_set          = 1'b1;
                    upd.wr_data.period   = entry.period;
                    upd.wr_data.deadline = time_ext + entry.period;
                end
            end
            OP_CLEAR_ONE:
            begin
                upd.act_clr = idx_ok;
            end
            OP_CLEAR_ALL:
            begin
                upd.clr_all   = 1'b1;
                upd.time_next = '0;
            end
            default:
            begin
                upd.time_next = time_now;
            end
        endcase
    end

    always_comb
    begin
        swept.period = entry.period;
        if (entry.deadline > DEADLINE_SHIFT)
        begin
            swept.deadline = entry.deadline - DEADLINE_SHIFT;
        end
        else
        begin
            swept.deadline = '0;
        end
    end

endmodule

### src/periodic_soft_timer_table.sv
// periodic_soft_timer_table: top level, control sequencer, time counter and entry memory
// uses pstt_pkg, pstt_ram and pstt_update
//
//  channel | dir | word        | handshake
//  cmd     | in  | cmd_word_t  | cmd_valid / cmd_stall
//  rsp     | out | rsp_word_t  | rsp_valid / rsp_stall
//
// each word goes through the entry memory read, then the update and write-back
// a tick that wraps the clock adds a sweep over all TIMER_COUNT entries of the memory,
// one entry a cycle, during which cmd_stall stays high
// reset clears the clock, the active bits and the response valid flag; the memory
// itself is not cleared, inactive entries are never read for their contents
// a stalled response holds the next word in its update cycle until the slot frees
module periodic_soft_timer_table
    import pstt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [30:0]            time_reg, time_next;
    logic [TIMER_COUNT-1:0] active_reg, active_next;
    logic [TIMER_AW-1:0]    sweep_reg, sweep_next;
    cmd_word_t              cmd_reg, cmd_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_word_t              rsp_reg, rsp_next;

    logic                accept;
    logic                slot_free;
    logic                commit;
    logic                idx_ok;
    logic [TIMER_AW-1:0] cmd_addr;
    logic [TIMER_AW-1:0] reg_addr;

    logic                ram_we;
    logic [TIMER_AW-1:0] ram_waddr;
    entry_t              ram_wdata;
    logic [TIMER_AW-1:0] ram_raddr;
    entry_t              ram_rdata;

    upd_t   upd;
    entry_t swept;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign commit    = (state_reg == ST_EXEC) && slot_free;
    assign cmd_addr  = TIMER_AW'(cmd.timer_index);
    assign reg_addr  = TIMER_AW'(cmd_reg.timer_index);
    assign idx_ok    = (32'(cmd_reg.timer_index) < TIMER_COUNT);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    pstt_update u_update (
        .op       (cmd_reg.op),
        .idx_ok   (idx_ok),
        .active   (active_reg[reg_addr]),
        .time_now (time_reg),
        .delay_ms (cmd_reg.delay_ms),
        .entry    (ram_rdata),
        .upd      (upd),
        .swept    (swept)
    );

    pstt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TIMER_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        active_next    = active_reg;
        sweep_next     = sweep_reg;
        cmd_next       = cmd_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = reg_addr;
        ram_wdata      = upd.wr_data;
        ram_raddr      = reg_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = cmd_addr;
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    ram_we         = upd.wr_en;
                    time_next      = upd.time_next;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{expired: upd.expired, now_ms: upd.time_next};
                    if (upd.clr_all)
                    begin
                        active_next = '0;
                    end
                    else if (upd.act_set)
                    begin
                        active_next[reg_addr] = 1'b1;
                    end
                    else if (upd.act_clr)
                    begin
                        active_next[reg_addr] = 1'b0;
                    end
                    if (upd.wrap)
                    begin
                        // first read of the sweep goes out with the tick itself
                        ram_raddr  = '0;
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = swept;
                ram_raddr  = sweep_reg + TIMER_AW'(1);
                sweep_next = sweep_reg + TIMER_AW'(1);
                if (32'(sweep_reg) == TIMER_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            active_reg    <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            active_reg    <= active_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

endmodule
